/* src/assert_macros.svh */
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define BBA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("buddy allocator check failed");

// Clocked assertion that also holds during reset.
`define BBA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("buddy allocator check failed");

`endif

/* src/bba_pkg.sv */
// Types, constants and codes for the buddy block allocator.
`default_nettype none

package bba_pkg;

    localparam int MAX_ORDER = 10;
    localparam int ADDR_W    = 10;
    localparam int SIZE_W    = 11;
    localparam int ORD_W     = 4;
    localparam int NODE_W    = MAX_ORDER + 1;
    localparam int MASK_W    = MAX_ORDER + 1;
    localparam int NODES     = 2 ** (MAX_ORDER + 1);
    localparam int UNITS     = 2 ** MAX_ORDER;

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOMEM   = 2'd1,
        ST_BADADDR = 2'd2
    } status_t;

    typedef struct packed {
        kind_t              kind;
        logic [SIZE_W-1:0]  request_size;
        logic [ADDR_W-1:0]  block_address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  granted_address;
        logic [ORD_W-1:0]   granted_order;
        status_t            status;
    } rsp_t;

    typedef struct packed {
        logic valid;
        rsp_t rsp;
    } core_res_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ROOT_CHK,
        S_DESC_RD,
        S_DESC_CHK,
        S_FREE_CHK,
        S_MERGE_RD,
        S_MERGE_CHK,
        S_UP_WR,
        S_UP_CHK,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

/* src/buddy_block_allocator_top.sv */
// Top level of the buddy block allocator: engine plus output register.
//
// Binary buddy allocator over 1024 units. After reset the block clears its node and order
// memories and holds req_stall high meanwhile. One request is handled at a time; the
// node-mask memory has a registered read, so every tree level takes a read state and a
// check state. An allocate descends from the root to a free block of order j, the
// smallest free order at or above the requested order k, then walks up from order k to
// the root; a free merges with each free buddy and then walks up to the root. Errors
// finish without a tree walk. A finished result waits in the output register while the next
// request is taken in.
`default_nettype none

module buddy_block_allocator_top import bba_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    core_res_t res;
    logic      take;
    logic      busy;
    logic      rsp_valid_reg, rsp_valid_next;
    rsp_t      rsp_reg, rsp_next;

    bba_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .busy      (busy),
        .res       (res),
        .take      (take)
    );

    assign req_stall = busy;
    assign take      = res.valid && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (take)
        begin
            rsp_next       = res.rsp;
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

/* src/bba_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* src/bba_core.sv */
// Allocation engine: node-mask tree walk and per-unit order table.
`default_nettype none

module bba_core import bba_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    input  wire req_t      req,
    output logic           busy,
    output core_res_t      res,
    input  wire logic      take
);

    // Each tree node holds one bit per order: a free block of that order lies in its subtree.
    logic                 m_we;
    logic [NODE_W-1:0]    m_waddr;
    logic [MASK_W-1:0]    m_wdata;
    logic [NODE_W-1:0]    m_raddr;
    logic [MASK_W-1:0]    m_rdata;

    logic                 a_we;
    logic [ADDR_W-1:0]    a_waddr;
    logic [ORD_W-1:0]     a_wdata;
    logic [ADDR_W-1:0]    a_raddr;
    logic [ORD_W-1:0]     a_rdata;

    state_t               state_reg, state_next;
    logic                 alloc_reg, alloc_next;
    logic [ORD_W-1:0]     ord_reg, ord_next;
    logic [ORD_W-1:0]     tgt_reg, tgt_next;
    logic [ORD_W-1:0]     k_reg, k_next;
    logic [NODE_W-1:0]    node_reg, node_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [MASK_W-1:0]    cur_reg, cur_next;
    logic [NODE_W-1:0]    clr_reg, clr_next;
    rsp_t                 out_reg, out_next;

    logic                 accept;
    logic [ORD_W:0]       pick;
    logic [ORD_W-1:0]     size_ord;
    logic                 oversize;
    logic                 desc_bit;
    logic [ORD_W-1:0]     ord_m1;
    logic [ADDR_W-1:0]    desc_addr;
    logic [NODE_W-1:0]    desc_child;
    logic [ORD_W-1:0]     free_ord;
    logic                 forced;
    logic [MASK_W-1:0]    sib_mask;

    function automatic logic [ORD_W-1:0] size_to_order(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] v;
        logic [ORD_W-1:0]  k;
        v = s - SIZE_W'(1);
        k = '0;
        for (int i = 0; i < SIZE_W; i++)
        begin
            if (v[i])
            begin
                k = ORD_W'(i + 1);
            end
        end
        if (s <= SIZE_W'(1))
        begin
            k = '0;
        end
        return k;
    endfunction

    // Smallest order at or above k that has a free block, with a found flag on top.
    function automatic logic [ORD_W:0] pick_order(input logic [MASK_W-1:0] m,
                                                  input logic [ORD_W-1:0] k);
        logic             found;
        logic [ORD_W-1:0] j;
        found = 1'b0;
        j     = '0;
        for (int i = MAX_ORDER; i >= 0; i--)
        begin
            if (i >= int'(k) && m[i])
            begin
                found = 1'b1;
                j     = ORD_W'(i);
            end
        end
        return {found, j};
    endfunction

    function automatic logic [NODE_W-1:0] node_of(input logic [ORD_W-1:0] k,
                                                  input logic [ADDR_W-1:0] a);
        logic [NODE_W-1:0] base;
        logic [NODE_W-1:0] off;
        base = NODE_W'(1) << (MAX_ORDER - int'(k));
        off  = {1'b0, a} >> k;
        return base + off;
    endfunction

    bba_ram #(.WIDTH(MASK_W), .DEPTH(NODES)) u_mask_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    bba_ram #(.WIDTH(ORD_W), .DEPTH(UNITS)) u_order_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    assign accept     = req_valid && (state_reg == S_IDLE);
    assign busy       = (state_reg != S_IDLE);
    assign pick       = pick_order(m_rdata, k_reg);
    assign size_ord   = size_to_order(req.request_size);
    assign oversize   = (req.request_size > SIZE_W'(UNITS));
    assign desc_bit   = m_rdata[tgt_reg];
    assign ord_m1     = ord_reg - ORD_W'(1);
    assign desc_addr  = desc_bit ? addr_reg : (addr_reg | (ADDR_W'(1) << ord_m1));
    assign desc_child = {node_reg[NODE_W-2:0], ~desc_bit};
    assign free_ord   = ((a_rdata - ORD_W'(1)) > ORD_W'(MAX_ORDER)) ?
                        ORD_W'(MAX_ORDER) : (a_rdata - ORD_W'(1));
    assign forced     = alloc_reg && (ord_reg < tgt_reg);
    assign sib_mask   = forced ? (MASK_W'(1) << ord_reg) : m_rdata;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == NODE_W'(NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.kind == KIND_FREE)
                    begin
                        state_next = S_FREE_CHK;
                    end
                    else if (oversize)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_ROOT_CHK;
                    end
                end
            end
            S_ROOT_CHK:
            begin
                if (!pick[ORD_W])
                begin
                    state_next = S_DONE;
                end
                else if (pick[ORD_W-1:0] == ORD_W'(MAX_ORDER))
                begin
                    state_next = S_UP_WR;
                end
                else
                begin
                    state_next = S_DESC_RD;
                end
            end
            S_DESC_RD:   state_next = S_DESC_CHK;
            S_DESC_CHK:  state_next = (ord_m1 == tgt_reg) ? S_UP_WR : S_DESC_RD;
            S_FREE_CHK:  state_next = (a_rdata == '0) ? S_DONE : S_MERGE_RD;
            S_MERGE_RD:
            begin
                state_next = (ord_reg == ORD_W'(MAX_ORDER)) ? S_UP_WR : S_MERGE_CHK;
            end
            S_MERGE_CHK: state_next = m_rdata[ord_reg] ? S_MERGE_RD : S_UP_WR;
            S_UP_WR:
            begin
                state_next = (ord_reg == ORD_W'(MAX_ORDER)) ? S_DONE : S_UP_CHK;
            end
            S_UP_CHK:    state_next = S_UP_WR;
            S_DONE:      state_next = take ? S_IDLE : S_DONE;
            default:     state_next = S_CLEAR;
        endcase
    end

    always_comb
    begin
        alloc_next = alloc_reg;
        ord_next   = ord_reg;
        tgt_next   = tgt_reg;
        k_next     = k_reg;
        node_next  = node_reg;
        addr_next  = addr_reg;
        cur_next   = cur_reg;
        clr_next   = clr_reg;
        out_next   = out_reg;
        m_we       = 1'b0;
        m_waddr    = node_reg;
        m_wdata    = cur_reg;
        m_raddr    = NODE_W'(1);
        a_we       = 1'b0;
        a_waddr    = addr_reg;
        a_wdata    = '0;
        a_raddr    = req.block_address;
        res.valid  = (state_reg == S_DONE);
        res.rsp    = out_reg;

        case (state_reg)
            S_CLEAR:
            begin
                m_we     = 1'b1;
                m_waddr  = clr_reg;
                m_wdata  = (clr_reg == NODE_W'(1)) ? (MASK_W'(1) << MAX_ORDER) : '0;
                a_we     = 1'b1;
                a_waddr  = clr_reg[ADDR_W-1:0];
                clr_next = clr_reg + NODE_W'(1);
            end
            S_IDLE:
            begin
                // Root mask and order entry are read here; data arrives next cycle.
                if (accept)
                begin
                    alloc_next = (req.kind == KIND_ALLOC);
                    k_next     = size_ord;
                    addr_next  = req.block_address;
                    out_next   = '{granted_address: '0, granted_order: '0, status: ST_OK};
                    if (req.kind == KIND_ALLOC && oversize)
                    begin
                        out_next.status = ST_NOMEM;
                    end
                end
            end
            S_ROOT_CHK:
            begin
                tgt_next  = pick[ORD_W-1:0];
                node_next = NODE_W'(1);
                ord_next  = ORD_W'(MAX_ORDER);
                addr_next = '0;
                if (!pick[ORD_W])
                begin
                    out_next.status = ST_NOMEM;
                end
                else if (pick[ORD_W-1:0] == ORD_W'(MAX_ORDER))
                begin
                    a_we      = 1'b1;
                    a_waddr   = '0;
                    a_wdata   = k_reg + ORD_W'(1);
                    node_next = node_of(k_reg, '0);
                    ord_next  = k_reg;
                    cur_next  = '0;
                    out_next.granted_order = k_reg;
                end
            end
            S_DESC_RD:
            begin
                m_raddr = {node_reg[NODE_W-2:0], 1'b0};
            end
            S_DESC_CHK:
            begin
                // Go left when the left child holds a free block of the target order.
                if (ord_m1 == tgt_reg)
                begin
                    a_we      = 1'b1;
                    a_waddr   = desc_addr;
                    a_wdata   = k_reg + ORD_W'(1);
                    node_next = node_of(k_reg, desc_addr);
                    ord_next  = k_reg;
                    addr_next = desc_addr;
                    cur_next  = '0;
                    out_next.granted_address = desc_addr;
                    out_next.granted_order   = k_reg;
                end
                else
                begin
                    node_next = desc_child;
                    ord_next  = ord_m1;
                    addr_next = desc_addr;
                end
            end
            S_FREE_CHK:
            begin
                if (a_rdata == '0)
                begin
                    out_next.status = ST_BADADDR;
                end
                else
                begin
                    a_we      = 1'b1;
                    a_waddr   = addr_reg;
                    a_wdata   = '0;
                    node_next = node_of(free_ord, addr_reg);
                    ord_next  = free_ord;
                    out_next.granted_order = free_ord;
                end
            end
            S_MERGE_RD:
            begin
                m_raddr = node_reg ^ NODE_W'(1);
                if (ord_reg == ORD_W'(MAX_ORDER))
                begin
                    cur_next = MASK_W'(1) << MAX_ORDER;
                end
            end
            S_MERGE_CHK:
            begin
                // Buddy free at this order: absorb it and climb.
                if (m_rdata[ord_reg])
                begin
                    m_we      = 1'b1;
                    m_waddr   = node_reg ^ NODE_W'(1);
                    m_wdata   = '0;
                    node_next = node_reg >> 1;
                    ord_next  = ord_reg + ORD_W'(1);
                end
                else
                begin
                    cur_next = MASK_W'(1) << ord_reg;
                end
            end
            S_UP_WR:
            begin
                m_we    = 1'b1;
                m_waddr = node_reg;
                m_wdata = cur_reg;
                m_raddr = node_reg ^ NODE_W'(1);
            end
            S_UP_CHK:
            begin
                // Below the split point the sibling is a freshly freed upper half.
                if (forced)
                begin
                    m_we    = 1'b1;
                    m_waddr = node_reg ^ NODE_W'(1);
                    m_wdata = sib_mask;
                end
                cur_next  = cur_reg | sib_mask;
                node_next = node_reg >> 1;
                ord_next  = ord_reg + ORD_W'(1);
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            alloc_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            alloc_reg <= alloc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ord_reg  <= ord_next;
        tgt_reg  <= tgt_next;
        k_reg    <= k_next;
        node_reg <= node_next;
        addr_reg <= addr_next;
        cur_reg  <= cur_next;
        out_reg  <= out_next;
    end

endmodule

`default_nettype wire

/* src/bba_checker.sv */
// Port-level checks for the buddy block allocator, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module bba_checker import bba_pkg::*; (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_stall,
    input wire logic rsp_valid,
    input wire logic rsp_stall,
    input wire rsp_t rsp
);

    `BBA_ASSERT(a_err_zero, clk, rst_n,
        (rsp_valid && rsp.status != ST_OK) |->
        (rsp.granted_address == '0 && rsp.granted_order == '0))
    `BBA_ASSERT(a_order_range, clk, rst_n, rsp_valid |-> (rsp.granted_order <= ORD_W'(MAX_ORDER)))
    `BBA_ASSERT(a_aligned, clk, rst_n,
        (rsp_valid && rsp.status == ST_OK) |->
        (((rsp.granted_address >> rsp.granted_order) << rsp.granted_order) == rsp.granted_address))
    `BBA_ASSERT(a_rsp_hold, clk, rst_n, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    `BBA_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> (!rsp_valid && req_stall))

endmodule

bind buddy_block_allocator_top bba_checker u_bba_checker (.*);

`default_nettype wire

/* verif/bba_checker.sv */
// Checker for the buddy block allocator: tracks the allocator state and compares responses.
`timescale 1ns / 1ps

module bba_scoreboard import bba_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    input  wire logic req_stall,
    input  wire req_t req,
    input  wire logic rsp_valid,
    input  wire logic rsp_stall,
    input  wire rsp_t rsp,
    output int        fail_count,
    output int        pending,
    output int        n_alloc_ok,
    output int        n_nomem,
    output int        n_badaddr,
    output int        n_free_ok
);

    logic        avail_bit [NODES];
    logic [3:0]  held_order [UNITS];
    rsp_t        expected_rsp [$];

    function automatic int node_index(int k, int a);
        return (1 << (MAX_ORDER - k)) + ((a & (UNITS - 1)) >> k);
    endfunction

    function automatic rsp_t apply_request(req_t r);
        rsp_t o;
        int k;
        int j;
        int a;
        int sz;
        bit hit;
        o = '{granted_address: '0, granted_order: '0, status: ST_OK};
        if (r.kind == KIND_ALLOC) begin
            sz = r.request_size;
            if (sz > UNITS) begin
                o.status = ST_NOMEM;
                return o;
            end
            k = 0;
            while (k < MAX_ORDER && (1 << k) < sz)
                k++;
            hit = 0;
            a = 0;
            for (j = k; j <= MAX_ORDER && !hit; j++) begin
                for (a = 0; a < UNITS; a += (1 << j))
                    if (avail_bit[node_index(j, a)]) begin
                        hit = 1;
                        break;
                    end
                if (hit)
                    break;
            end
            if (!hit) begin
                o.status = ST_NOMEM;
                return o;
            end
            avail_bit[node_index(j, a)] = 0;
            while (j > k) begin
                j--;
                avail_bit[node_index(j, a + (1 << j))] = 1;
            end
            held_order[a] = 4'(k + 1);
            o.granted_address = ADDR_W'(a);
            o.granted_order = ORD_W'(k);
        end else begin
            a = r.block_address;
            if (held_order[a] == 0) begin
                o.status = ST_BADADDR;
                return o;
            end
            k = held_order[a] - 1;
            o.granted_order = ORD_W'(k);
            held_order[a] = 0;
            while (k < MAX_ORDER) begin
                if (!avail_bit[node_index(k, a ^ (1 << k))])
                    break;
                avail_bit[node_index(k, a ^ (1 << k))] = 0;
                a &= ~(1 << k);
                k++;
            end
            avail_bit[node_index(k, a)] = 1;
        end
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        rsp_t got;
        int   errs;
        errs = 0;
        if (!rst_n) begin
            for (int i = 0; i < NODES; i++)
                avail_bit[i] = 0;
            for (int i = 0; i < UNITS; i++)
                held_order[i] = 0;
            avail_bit[node_index(MAX_ORDER, 0)] = 1;
            expected_rsp.delete();
            fail_count <= 0;
            pending <= 0;
            n_alloc_ok <= 0;
            n_nomem <= 0;
            n_badaddr <= 0;
            n_free_ok <= 0;
        end else begin
            if (rsp_valid && !rsp_stall) begin
                got = rsp;
                if (expected_rsp.size() == 0) begin
                    $error("response beat with nothing expected");
                    errs++;
                end else begin
                    want = expected_rsp.pop_front();
                    if (got.granted_address !== want.granted_address) begin
                        $error("granted_address expected %0d actual %0d",
                               want.granted_address, got.granted_address);
                        errs++;
                    end
                    if (got.granted_order !== want.granted_order) begin
                        $error("granted_order expected %0d actual %0d",
                               want.granted_order, got.granted_order);
                        errs++;
                    end
                    if (got.status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, got.status);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            if (req_valid && !req_stall) begin
                want = apply_request(req);
                expected_rsp.push_back(want);
                if (want.status == ST_NOMEM)
                    n_nomem <= n_nomem + 1;
                else if (want.status == ST_BADADDR)
                    n_badaddr <= n_badaddr + 1;
                else if (req.kind == KIND_ALLOC)
                    n_alloc_ok <= n_alloc_ok + 1;
                else
                    n_free_ok <= n_free_ok + 1;
            end
            pending <= expected_rsp.size();
        end
    end

endmodule

/* verif/tb_top.sv */
// Testbench top for the buddy block allocator: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_top;
    import bba_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic req_valid = 0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 0;
    rsp_t rsp;
    int fail_count, pending, n_alloc_ok, n_nomem, n_badaddr, n_free_ok;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count = 0;
    logic [ADDR_W-1:0] live_blocks [$];

    localparam int CYCLE_LIMIT = 600000;

    always #1 clk = ~clk;

    buddy_block_allocator_top u_dut (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_stall(req_stall),
        .req(req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    bba_scoreboard u_checker (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_stall(req_stall),
        .req(req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .fail_count(fail_count), .pending(pending), .n_alloc_ok(n_alloc_ok),
        .n_nomem(n_nomem), .n_badaddr(n_badaddr), .n_free_ok(n_free_ok)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Track granted blocks so most frees hit live ones.
    always @(posedge clk)
    begin
        if (rsp_valid && !rsp_stall && rsp.status == ST_OK && rsp.granted_address != 0)
            live_blocks.push_back(rsp.granted_address);
    end

    task automatic send_beat(req_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 0;
            @(posedge clk);
        end
        req_valid <= 1;
        req <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic send_alloc(int sz);
        req_t r;
        r = '0;
        r.kind = KIND_ALLOC;
        r.request_size = SIZE_W'(sz);
        r.block_address = ADDR_W'($urandom);
        send_beat(r);
    endtask

    task automatic send_free(int addr);
        req_t r;
        r = '0;
        r.kind = KIND_FREE;
        r.block_address = ADDR_W'(addr);
        r.request_size = SIZE_W'($urandom);
        send_beat(r);
    endtask

    task automatic random_beat();
        int pick;
        int idx;
        int sz;
        pick = $urandom_range(99);
        if (pick < 45) begin
            case ($urandom_range(3))
                0: sz = $urandom_range(2);
                1: sz = $urandom_range(16);
                2: sz = $urandom_range(128);
                default: sz = $urandom_range(2047);
            endcase
            send_alloc(sz);
        end else if (pick < 90 && live_blocks.size() > 0) begin
            idx = $urandom_range(live_blocks.size() - 1);
            send_free(live_blocks[idx]);
            live_blocks.delete(idx);
        end else if (pick < 95) begin
            send_free(0);
        end else begin
            send_free($urandom_range(1023));
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1;
        // Directed: whole pool, double free, oversize, zero, split chain, free of a non-start.
        send_alloc(1024);
        send_alloc(1);
        send_free(0);
        send_free(0);
        send_alloc(1025);
        send_alloc(2047);
        send_alloc(0);
        send_alloc(1);
        send_alloc(2);
        send_alloc(3);
        send_alloc(513);
        send_alloc(512);
        send_free(1023);
        send_free(1);
        send_free(4);
        send_free(0);
        send_free(2);
        send_free(512);
        send_alloc(1024);
        send_free(1022);
        send_free(0);
        // Hold until the pipeline drains.
        req_valid <= 0;
        @(posedge clk);
        while (pending != 0 || req_stall)
            @(posedge clk);
        live_blocks.delete();
        send_idle_pct = 28;
        recv_idle_pct = 83;
        repeat (560) random_beat();
        send_idle_pct = 83;
        recv_idle_pct = 28;
        repeat (560) random_beat();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (560) random_beat();
        req_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        $display("covered %0d grants, %0d frees, %0d out-of-memory, %0d bad-address",
                 n_alloc_ok, n_free_ok, n_nomem, n_badaddr);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
